[rtl/hhpb_pkg.sv]
// ----------------------------------------------------------------------------
// hhpb_pkg
// Shared widths, reset values and control types of the hue histogram peak
// band mask unit.
// ----------------------------------------------------------------------------
package hhpb_pkg;

  localparam int HUE_W        = 8;
  localparam int BAND_W       = 7;
  localparam int HUE_BINS_DEF = 180;
  localparam int COUNT_W_DEF  = 20;

  localparam logic [BAND_W-1:0] BAND_RESET = 7'd5;

  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_MASK = 1'b1;

  localparam logic OP_MODEL = 1'b0;
  localparam logic OP_IMAGE = 1'b1;

  // Control from the sequencer to the peak tracker
  typedef struct packed {
    logic             start;  // clear best before a new scan
    logic             vld;    // count from the memory belongs to the scan
    logic [HUE_W-1:0] idx;    // bin index of that count
  } scan_ctl_t;

endpackage

[rtl/hue_histogram_peak_band_mask_unit.sv]
// ----------------------------------------------------------------------------
// hue_histogram_peak_band_mask_unit
// Hue histogram, peak search and band mask over a sample stream.
// ----------------------------------------------------------------------------
// After reset the unit sweeps all HUE_BINS bins (180 by default) of the
// bin memory to zero and takes no transaction in that time. An image sample
// (op = 1) yields a registered mask result. A model sample (op = 0) is a
// memory read followed by a write back of the incremented, saturating
// count. A model sample flagged last_model then scans the bin memory one
// bin per cycle through its single read port, clearing each bin, and
// delivers the peak report once the output register is free. A new sample
// is taken only when the output register is empty or is read in the same
// cycle, so a waiting result holds the input.
// ----------------------------------------------------------------------------
module hue_histogram_peak_band_mask_unit
  import hhpb_pkg::*;
#(
  parameter int HUE_BINS   = HUE_BINS_DEF,
  parameter int COUNT_BITS = COUNT_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [BAND_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [HUE_W-1:0]  in_hue,
  input  logic              in_last_model,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [HUE_W-1:0]  out_peak_hue,
  output logic              out_inside_res
);

  localparam int IDX_W = (HUE_BINS > 1) ? $clog2(HUE_BINS) : 1;
  localparam logic [HUE_W:0]      BINS_EXT  = (HUE_W+1)'(HUE_BINS);
  localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(HUE_BINS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_SCAN,
    ST_TAIL,
    ST_REPORT
  } state_t;

  state_t state_r, state_nxt;

  logic [BAND_W-1:0] band_r, band_nxt;
  logic [HUE_W-1:0]  peak_r, peak_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;       // clear / scan address
  logic [IDX_W-1:0]  inc_addr_r, inc_addr_nxt;
  logic              inc_vld_r, inc_vld_nxt;
  logic              last_r, last_nxt;
  logic              rdv_r, rdv_nxt;       // scan read data arrives this cycle
  logic [IDX_W-1:0]  rdv_idx_r, rdv_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [HUE_W-1:0]  out_peak_r, out_peak_nxt;
  logic              out_inside_r, out_inside_nxt;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] rd_data;

  scan_ctl_t        scan_ctl;
  logic [HUE_W-1:0] best_idx;

  logic             out_free;
  logic             in_acc;
  logic [HUE_W-1:0] hue_diff;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign hue_diff = (in_hue >= peak_r) ? (in_hue - peak_r) : (peak_r - in_hue);

  hhpb_bin_ram #(
    .DEPTH (HUE_BINS),
    .WIDTH (COUNT_BITS),
    .AW    (IDX_W)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hhpb_peak_track #(
    .COUNT_BITS (COUNT_BITS)
  ) u_peak_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .count    (rd_data),
    .best_idx (best_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    band_nxt       = cfg_we ? cfg_wdata : band_r;
    peak_nxt       = peak_r;
    idx_nxt        = idx_r;
    inc_addr_nxt   = inc_addr_r;
    inc_vld_nxt    = inc_vld_r;
    last_nxt       = last_r;
    rdv_nxt        = 1'b0;
    rdv_idx_nxt    = rdv_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_peak_nxt   = out_peak_r;
    out_inside_nxt = out_inside_r;

    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = idx_r;

    scan_ctl.start = 1'b0;
    scan_ctl.vld   = rdv_r;
    scan_ctl.idx   = HUE_W'(rdv_idx_r);

    // Zero the bin whose count just came back from a scan read
    if (rdv_r) begin
      wr_en   = 1'b1;
      wr_addr = rdv_idx_r;
      wr_data = '0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_IMAGE) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_MASK;
            out_peak_nxt   = peak_r;
            out_inside_nxt = ({1'b0, hue_diff} < (HUE_W+1)'(band_r));
          end else begin
            inc_vld_nxt  = ({1'b0, in_hue} < BINS_EXT);
            inc_addr_nxt = IDX_W'(in_hue);
            last_nxt     = in_last_model;
            rd_en        = 1'b1;
            rd_addr      = IDX_W'(in_hue);
            state_nxt    = ST_INC;
          end
        end
      end
      ST_INC: begin
        if (inc_vld_r && (rd_data != COUNT_MAX)) begin
          wr_en   = 1'b1;
          wr_addr = inc_addr_r;
          wr_data = rd_data + 1'b1;
        end
        if (last_r) begin
          scan_ctl.start = 1'b1;
          idx_nxt        = '0;
          state_nxt      = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        rd_en       = 1'b1;
        rd_addr     = idx_r;
        rdv_nxt     = 1'b1;
        rdv_idx_nxt = idx_r;
        idx_nxt     = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // last count is folded into the tracker at this edge
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          peak_nxt       = best_idx;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_PEAK;
          out_peak_nxt   = best_idx;
          out_inside_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      band_r      <= BAND_RESET;
      peak_r      <= '0;
      idx_r       <= '0;
      inc_vld_r   <= 1'b0;
      last_r      <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      band_r      <= band_nxt;
      peak_r      <= peak_nxt;
      idx_r       <= idx_nxt;
      inc_vld_r   <= inc_vld_nxt;
      last_r      <= last_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    inc_addr_r   <= inc_addr_nxt;
    rdv_idx_r    <= rdv_idx_nxt;
    out_kind_r   <= out_kind_nxt;
    out_peak_r   <= out_peak_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_peak_hue   = out_peak_r;
  assign out_inside_res = out_inside_r;

endmodule

[rtl/hhpb_bin_ram.sv]
// ----------------------------------------------------------------------------
// hhpb_bin_ram
// Histogram bin memory: one write port, one read port, registered read data
// (read-first on an address collision).
// ----------------------------------------------------------------------------
module hhpb_bin_ram #(
  parameter int DEPTH = 180,
  parameter int WIDTH = 20,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/hhpb_peak_track.sv]
// ----------------------------------------------------------------------------
// hhpb_peak_track
// Running maximum over the bin counts streamed out of the memory during a
// scan; a count must be strictly greater to replace the best, so the lowest
// bin wins ties.
// ----------------------------------------------------------------------------
module hhpb_peak_track
  import hhpb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scan_ctl_t             ctl,
  input  logic [COUNT_BITS-1:0] count,
  output logic [HUE_W-1:0]      best_idx
);

  logic [HUE_W-1:0]      best_idx_r, best_idx_nxt;
  logic [COUNT_BITS-1:0] best_cnt_r, best_cnt_nxt;

  always_comb begin
    best_idx_nxt = best_idx_r;
    best_cnt_nxt = best_cnt_r;
    if (ctl.start) begin
      best_idx_nxt = '0;
      best_cnt_nxt = '0;
    end else if (ctl.vld && (count > best_cnt_r)) begin
      best_idx_nxt = ctl.idx;
      best_cnt_nxt = count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_idx_r <= '0;
      best_cnt_r <= '0;
    end else begin
      best_idx_r <= best_idx_nxt;
      best_cnt_r <= best_cnt_nxt;
    end
  end

  assign best_idx = best_idx_r;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives model and image hue samples into the histogram peak band mask unit
// and checks every peak report and mask bit against a cycle-free histogram
// tracker kept alongside. A short table of directed rows runs first, then
// frames of clustered model samples followed by image samples near the peak.
// ----------------------------------------------------------------------------
module testbench;
  import hhpb_pkg::*;

  // Counter width as the block is built by default
  localparam int CNT_W = COUNT_W_DEF;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int NBINS = HUE_BINS_DEF;
  localparam int RAND_ITEMS = 1000;
  localparam int MAX_SHOWN = 100;

  localparam bit ROW_ITEM = 1'b0;
  localparam bit ROW_CFG  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [HUE_W-1:0] peak;
    logic             in_band;
  } hue_res_t;

  typedef struct {
    bit       row_kind;
    logic     op;
    int       hue;     // band value on a register row
    logic     last;
    int       reps;
    bit       fixed;
    hue_res_t want;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BAND_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic              in_op;
  logic [HUE_W-1:0]  in_hue;
  logic              in_last_model;
  logic              out_valid;
  logic              out_ready;
  logic              out_kind;
  logic [HUE_W-1:0]  out_peak_hue;
  logic              out_inside_res;

  // Tracker state
  logic [CNT_W-1:0]  bin_tally [NBINS];
  logic [HUE_W-1:0]  peak_hold;
  logic [BAND_W-1:0] band_cfg;

  hue_res_t  due_reports[$];
  plan_row_t plan[$];
  int        mismatches;
  int        sent_items;
  bit        quiet;

  hue_histogram_peak_band_mask_unit #(
    .HUE_BINS   (NBINS),
    .COUNT_BITS (CNT_W)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_hue         (in_hue),
    .in_last_model  (in_last_model),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_peak_hue   (out_peak_hue),
    .out_inside_res (out_inside_res)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Advance the histogram by one accepted sample and queue the result it owes
  task automatic histogram_and_mask(input logic op, input logic [HUE_W-1:0] hue,
                                    input logic last);
    hue_res_t         res;
    int               best;
    logic [CNT_W-1:0] best_cnt;
    logic [HUE_W-1:0] hue_diff;
    if (op == OP_MODEL) begin
      if (hue < NBINS && bin_tally[hue] != CNT_MAX) begin
        bin_tally[hue] = bin_tally[hue] + 1'b1;
      end
      if (last) begin
        best = 0;
        best_cnt = '0;
        for (int k = 0; k < NBINS; k++) begin
          if (bin_tally[k] > best_cnt) begin
            best_cnt = bin_tally[k];
            best = k;
          end
          bin_tally[k] = '0;
        end
        peak_hold = best[HUE_W-1:0];
        res.kind = KIND_PEAK;
        res.peak = peak_hold;
        res.in_band = 1'b0;
        due_reports = {due_reports, res};
      end
    end else begin
      hue_diff = (hue >= peak_hold) ? hue - peak_hold : peak_hold - hue;
      res.kind = KIND_MASK;
      res.peak = peak_hold;
      res.in_band = (hue_diff < band_cfg);
      due_reports = {due_reports, res};
    end
  endtask

  task automatic send_sample(input logic op, input logic [HUE_W-1:0] hue, input logic last,
                             input bit fixed, input hue_res_t want);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_hue        <= hue;
    in_last_model <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    histogram_and_mask(op, hue, last);
    if (fixed) begin
      due_reports[due_reports.size()-1] = want;
    end
    sent_items++;
  endtask

  task automatic write_band(input logic [BAND_W-1:0] value);
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    // a model sample leaves no result behind; let its write back or scan drain
    repeat (NBINS + 8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    band_cfg = value;
  endtask

  task automatic add_row(input bit row_kind, input logic op, input int hue, input logic last,
                         input int reps, input bit fixed, input logic kind, input int peak,
                         input logic in_band);
    plan_row_t row;
    row.row_kind = row_kind;
    row.op = op;
    row.hue = hue;
    row.last = last;
    row.reps = reps;
    row.fixed = fixed;
    row.want.kind = kind;
    row.want.peak = peak[HUE_W-1:0];
    row.want.in_band = in_band;
    plan = {plan, row};
  endtask

  function automatic int model_hue(input int center, input int spread);
    int h;
    if ($urandom_range(9) == 0) begin
      return $urandom_range(NBINS, 255);
    end
    h = center + $urandom_range(0, 2 * spread) - spread;
    if (h < 0) h = 0;
    if (h > NBINS - 1) h = NBINS - 1;
    return h;
  endfunction

  // Result side: random back-pressure and in-order compare
  initial begin
    hue_res_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          report_mismatch("result with nothing outstanding, kind", out_kind, -1);
        end else begin
          want = due_reports.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", out_kind, want.kind);
          if (out_peak_hue !== want.peak)
            report_mismatch("peak_hue", out_peak_hue, want.peak);
          if (out_inside_res !== want.in_band)
            report_mismatch("inside_res", out_inside_res, want.in_band);
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  initial begin
    int phase;
    int n;
    int m;
    int w;
    int h;
    int center;
    int spread;
    int pick;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= BAND_RESET;
    in_valid      <= 1'b0;
    in_op         <= OP_MODEL;
    in_hue        <= '0;
    in_last_model <= 1'b0;
    quiet = 1'b0;
    mismatches = 0;
    sent_items = 0;
    for (int k = 0; k < NBINS; k++) bin_tally[k] = '0;
    peak_hold = '0;
    band_cfg = BAND_RESET;

    // Reset band of 5 and peak of 0 before any scan; flag on an image sample is ignored
    add_row(ROW_ITEM, OP_IMAGE, 0, 1'b1, 1, 1'b1, KIND_MASK, 0, 1'b1);
    add_row(ROW_ITEM, OP_IMAGE, 4, 1'b0, 1, 1'b1, KIND_MASK, 0, 1'b1);
    add_row(ROW_ITEM, OP_IMAGE, 5, 1'b0, 1, 1'b1, KIND_MASK, 0, 1'b0);
    add_row(ROW_ITEM, OP_IMAGE, 255, 1'b0, 1, 1'b1, KIND_MASK, 0, 1'b0);
    // Empty histogram: out of range hue is dropped but still starts the scan
    add_row(ROW_ITEM, OP_MODEL, 200, 1'b1, 1, 1'b1, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_MODEL, 0, 1'b0, 3, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_MODEL, 179, 1'b0, 3, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_MODEL, 255, 1'b0, 5, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_MODEL, 179, 1'b1, 1, 1'b1, KIND_PEAK, 179, 1'b0);
    add_row(ROW_ITEM, OP_IMAGE, 179, 1'b0, 1, 1'b1, KIND_MASK, 179, 1'b1);
    add_row(ROW_ITEM, OP_IMAGE, 175, 1'b0, 1, 1'b1, KIND_MASK, 179, 1'b1);
    add_row(ROW_ITEM, OP_IMAGE, 174, 1'b0, 1, 1'b1, KIND_MASK, 179, 1'b0);
    // Tie goes to the lower bin; old counts must be gone after the scan
    add_row(ROW_ITEM, OP_MODEL, 90, 1'b0, 2, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_MODEL, 60, 1'b0, 1, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_MODEL, 60, 1'b1, 1, 1'b1, KIND_PEAK, 60, 1'b0);
    // Equal counts in two bins, the higher one filled first; the lower one wins
    add_row(ROW_ITEM, OP_MODEL, 100, 1'b0, 3, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_MODEL, 40, 1'b0, 2, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_MODEL, 40, 1'b1, 1, 1'b1, KIND_PEAK, 40, 1'b0);
    // Band extremes around a peak of 40
    add_row(ROW_CFG, OP_MODEL, 0, 1'b0, 1, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_IMAGE, 40, 1'b0, 1, 1'b1, KIND_MASK, 40, 1'b0);
    add_row(ROW_CFG, OP_MODEL, 127, 1'b0, 1, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_IMAGE, 0, 1'b0, 1, 1'b1, KIND_MASK, 40, 1'b1);
    add_row(ROW_CFG, OP_MODEL, 1, 1'b0, 1, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_IMAGE, 40, 1'b0, 1, 1'b1, KIND_MASK, 40, 1'b1);
    add_row(ROW_ITEM, OP_IMAGE, 41, 1'b0, 1, 1'b1, KIND_MASK, 40, 1'b0);
    add_row(ROW_CFG, OP_MODEL, 90, 1'b0, 1, 1'b0, KIND_PEAK, 0, 1'b0);
    add_row(ROW_ITEM, OP_IMAGE, 129, 1'b0, 1, 1'b1, KIND_MASK, 40, 1'b1);
    add_row(ROW_ITEM, OP_IMAGE, 130, 1'b0, 1, 1'b1, KIND_MASK, 40, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].row_kind == ROW_CFG) begin
        write_band(plan[i].hue[BAND_W-1:0]);
      end else begin
        repeat (plan[i].reps) begin
          send_sample(plan[i].op, plan[i].hue[HUE_W-1:0], plan[i].last,
                      plan[i].fixed, plan[i].want);
        end
      end
    end

    // Frames: a cluster of model samples, then image samples around the peak
    sent_items = 0;
    phase = 0;
    while (sent_items < RAND_ITEMS) begin
      quiet = (phase >= 8 && phase < 14);
      if (phase % 3 == 0) begin
        pick = $urandom_range(5);
        case (pick)
          0: write_band(7'd0);
          1: write_band(7'd1);
          2: write_band(7'd90);
          3: write_band(7'd127);
          default: write_band(BAND_W'($urandom_range(1, 90)));
        endcase
      end
      if ($urandom_range(9) != 0) begin
        center = $urandom_range(0, NBINS - 1);
        spread = $urandom_range(0, 12);
        n = $urandom_range(0, 40);
        repeat (n) begin
          if ($urandom_range(9) == 0) begin
            send_sample(OP_IMAGE, HUE_W'($urandom_range(0, 255)), 1'($urandom_range(1)),
                        1'b0, '0);
          end else begin
            send_sample(OP_MODEL, HUE_W'(model_hue(center, spread)), 1'b0, 1'b0, '0);
          end
        end
        // drop the closing flag now and then so counts carry into the next frame
        if ($urandom_range(9) != 0) begin
          send_sample(OP_MODEL, HUE_W'(model_hue(center, spread)), 1'b1, 1'b0, '0);
        end
      end
      m = $urandom_range(1, 40);
      w = int'(band_cfg) + 2;
      repeat (m) begin
        if ($urandom_range(4) == 0) begin
          h = $urandom_range(0, 255);
        end else begin
          h = int'(peak_hold) + $urandom_range(0, 2 * w) - w;
          if (h < 0) h = 0;
          if (h > 255) h = 255;
        end
        send_sample(OP_IMAGE, h[HUE_W-1:0], 1'($urandom_range(1)), 1'b0, '0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    quiet = 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (NBINS + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
